// File: rtl/core/cau_pkg.sv
// Shared types and operation codes for the complex arithmetic unit.
`default_nettype none

package cau_pkg;

   // Operation codes carried with each request.
   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_MAG = 3'd4
   } op_type;

   // Control that travels alongside the data in every pipeline stage.
   typedef struct packed {
      logic   valid;
      op_type op;
      logic   dz;
      logic   neg_re;
      logic   neg_im;
   } ctl_type;

endpackage

`default_nettype wire

// File: rtl/core/complex_arithmetic_unit_top.sv
// Top level of the complex arithmetic unit: front end, digit chain and back end.
//
// Takes one request per clock cycle unless a stalled response freezes the pipeline,
// and returns one response per request, in order. Each request passes through
// four front stages for capture, products, sums and scaling, WORD_WIDTH + 1
// digit stages that form the quotients and the square root one bit each, and
// two back stages for rounding, saturation and the response register. The digit
// chain makes up most of the pipeline depth.
// A stalled response freezes the whole pipeline; no request is lost.
`default_nettype none

module complex_arithmetic_unit_top #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [2:0]                  req_operation,
   input  wire logic signed [WORD_WIDTH-1:0] req_a_real,
   input  wire logic signed [WORD_WIDTH-1:0] req_a_imag,
   input  wire logic signed [WORD_WIDTH-1:0] req_b_real,
   input  wire logic signed [WORD_WIDTH-1:0] req_b_imag,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [WORD_WIDTH-1:0]     rsp_res_real,
   output logic signed [WORD_WIDTH-1:0]     rsp_res_imag,
   output logic                             rsp_div_by_zero,
   output logic                             rsp_saturated
);

   localparam int W  = WORD_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int DW = 3 * W + F + 1;
   localparam int NS = W + 1;

   // The pipeline moves unless a finished response is held up.
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   cau_pkg::ctl_type ch_ctl   [0:NS];
   logic [DW-1:0]    ch_rem_a [0:NS];
   logic [DW-1:0]    ch_rem_b [0:NS];
   logic [W:0]       ch_q_a   [0:NS];
   logic [W:0]       ch_q_b   [0:NS];
   logic [2*W-1:0]   ch_den   [0:NS];

   cau_front #(.W(W), .F(F)) u_front (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .up_valid     (req_valid),
      .up_operation (req_operation),
      .up_a_real    (req_a_real),
      .up_a_imag    (req_a_imag),
      .up_b_real    (req_b_real),
      .up_b_imag    (req_b_imag),
      .dn_ctl       (ch_ctl[0]),
      .dn_rem_a     (ch_rem_a[0]),
      .dn_rem_b     (ch_rem_b[0]),
      .dn_den       (ch_den[0])
   );

   assign ch_q_a[0] = '0;
   assign ch_q_b[0] = '0;

   // Digit chain, most significant bit first.
   for (genvar j = 0; j < NS; j++) begin : g_digit
      cau_iter #(.W(W), .F(F), .K(W - j)) u_iter (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .up_ctl   (ch_ctl[j]),
         .up_rem_a (ch_rem_a[j]),
         .up_rem_b (ch_rem_b[j]),
         .up_q_a   (ch_q_a[j]),
         .up_q_b   (ch_q_b[j]),
         .up_den   (ch_den[j]),
         .dn_ctl   (ch_ctl[j+1]),
         .dn_rem_a (ch_rem_a[j+1]),
         .dn_rem_b (ch_rem_b[j+1]),
         .dn_q_a   (ch_q_a[j+1]),
         .dn_q_b   (ch_q_b[j+1]),
         .dn_den   (ch_den[j+1])
      );
   end

   cau_back #(.W(W), .F(F)) u_back (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .up_ctl          (ch_ctl[NS]),
      .up_rem_a        (ch_rem_a[NS]),
      .up_rem_b        (ch_rem_b[NS]),
      .up_q_a          (ch_q_a[NS]),
      .up_q_b          (ch_q_b[NS]),
      .rsp_valid       (rsp_valid),
      .rsp_res_real    (rsp_res_real),
      .rsp_res_imag    (rsp_res_imag),
      .rsp_div_by_zero (rsp_div_by_zero),
      .rsp_saturated   (rsp_saturated)
   );

   // A divide by zero gives a clean zero response with no clipping.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |->
         rsp_res_real == '0 && rsp_res_imag == '0 && !rsp_saturated)
      else $error("divide by zero response not cleared");

   // A clipped response has at least one part sitting on a range bound.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_res_real == {1'b0, {(W-1){1'b1}}} || rsp_res_real == {1'b1, {(W-1){1'b0}}} ||
         rsp_res_imag == {1'b0, {(W-1){1'b1}}} || rsp_res_imag == {1'b1, {(W-1){1'b0}}})
      else $error("saturation flag without a bound value");

   // A frozen pipeline keeps the last stage's response unchanged.
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(rsp_res_real) && $stable(rsp_res_imag))
      else $error("response changed while pipeline frozen");

endmodule

`default_nettype wire

// File: rtl/core/cau_front.sv
// Front end: operand capture, products, sums and preparation of magnitudes.
`default_nettype none

module cau_front #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  up_valid,
   input  wire logic [2:0]            up_operation,
   input  wire logic signed [W-1:0]   up_a_real,
   input  wire logic signed [W-1:0]   up_a_imag,
   input  wire logic signed [W-1:0]   up_b_real,
   input  wire logic signed [W-1:0]   up_b_imag,
   output cau_pkg::ctl_type           dn_ctl,
   output logic [3*W+F:0]             dn_rem_a,
   output logic [3*W+F:0]             dn_rem_b,
   output logic [2*W-1:0]             dn_den
);

   localparam int PW = 2 * W;
   localparam int XW = 2 * W + 1;
   localparam int DW = 3 * W + F + 1;
   localparam logic [DW-1:0] HALF = (DW'(1) << F) >> 1;

   // Stage one: capture the request.
   cau_pkg::ctl_type c1_ff, c1_in;
   logic signed [W-1:0] ar_ff, ai_ff, br_ff, bi_ff;

   always_comb begin
      c1_in        = '0;
      c1_in.valid  = up_valid;
      c1_in.op     = cau_pkg::op_type'(up_operation);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
      end else if (adv) begin
         c1_ff <= c1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ar_ff <= up_a_real;
         ai_ff <= up_a_imag;
         br_ff <= up_b_real;
         bi_ff <= up_b_imag;
      end
   end

   // Stage two: all partial products, plus the plain sum or difference.
   cau_pkg::ctl_type c2_ff;
   logic signed [PW-1:0] rr_ff, ii_ff, ri_ff, ir_ff, aa_ff, a2_ff, bb_ff, b2_ff;
   logic signed [PW-1:0] rr_in, ii_in, ri_in, ir_in, aa_in, a2_in, bb_in, b2_in;
   logic signed [W:0]    s_re_ff, s_im_ff, s_re_in, s_im_in;

   always_comb begin
      rr_in = PW'(ar_ff) * PW'(br_ff);
      ii_in = PW'(ai_ff) * PW'(bi_ff);
      ri_in = PW'(ar_ff) * PW'(bi_ff);
      ir_in = PW'(ai_ff) * PW'(br_ff);
      aa_in = PW'(ar_ff) * PW'(ar_ff);
      a2_in = PW'(ai_ff) * PW'(ai_ff);
      bb_in = PW'(br_ff) * PW'(br_ff);
      b2_in = PW'(bi_ff) * PW'(bi_ff);
      if (c1_ff.op == cau_pkg::OP_SUB) begin
         s_re_in = (W+1)'(ar_ff) - (W+1)'(br_ff);
         s_im_in = (W+1)'(ai_ff) - (W+1)'(bi_ff);
      end else begin
         s_re_in = (W+1)'(ar_ff) + (W+1)'(br_ff);
         s_im_in = (W+1)'(ai_ff) + (W+1)'(bi_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_ff <= '0;
      end else if (adv) begin
         c2_ff <= c1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rr_ff   <= rr_in;
         ii_ff   <= ii_in;
         ri_ff   <= ri_in;
         ir_ff   <= ir_in;
         aa_ff   <= aa_in;
         a2_ff   <= a2_in;
         bb_ff   <= bb_in;
         b2_ff   <= b2_in;
         s_re_ff <= s_re_in;
         s_im_ff <= s_im_in;
      end
   end

   // Stage three: form exact real and imaginary parts from the products or the sums.
   cau_pkg::ctl_type c3_ff;
   logic signed [XW-1:0] x_re_ff, x_im_ff, x_re_in, x_im_in;
   logic [PW-1:0]        den_ff, den_in;

   always_comb begin
      den_in = $unsigned(bb_ff) + $unsigned(b2_ff);
      unique case (c2_ff.op)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
            x_re_in = XW'(s_re_ff);
            x_im_in = XW'(s_im_ff);
         end
         cau_pkg::OP_MUL: begin
            x_re_in = XW'(rr_ff) - XW'(ii_ff);
            x_im_in = XW'(ri_ff) + XW'(ir_ff);
         end
         cau_pkg::OP_DIV: begin
            x_re_in = XW'(rr_ff) + XW'(ii_ff);
            x_im_in = XW'(ir_ff) - XW'(ri_ff);
         end
         cau_pkg::OP_MAG: begin
            x_re_in = XW'(aa_ff) + XW'(a2_ff);
            x_im_in = '0;
         end
         default: begin
            x_re_in = '0;
            x_im_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c3_ff <= '0;
      end else if (adv) begin
         c3_ff <= c2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_re_ff <= x_re_in;
         x_im_ff <= x_im_in;
         den_ff  <= den_in;
      end
   end

   // Stage four: split into sign and magnitude, round products, scale dividends.
   cau_pkg::ctl_type c4_ff, c4_in;
   logic [DW-1:0] rem_a_ff, rem_b_ff, rem_a_in, rem_b_in;
   logic [PW-1:0] den4_ff;
   logic [XW-1:0] abs_re, abs_im;

   always_comb begin
      abs_re = x_re_ff[XW-1] ? XW'(-x_re_ff) : XW'(x_re_ff);
      abs_im = x_im_ff[XW-1] ? XW'(-x_im_ff) : XW'(x_im_ff);
      c4_in        = c3_ff;
      c4_in.neg_re = x_re_ff[XW-1];
      c4_in.neg_im = x_im_ff[XW-1];
      c4_in.dz     = (c3_ff.op == cau_pkg::OP_DIV) && (den_ff == '0);
      unique case (c3_ff.op)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MAG: begin
            rem_a_in = DW'(abs_re);
            rem_b_in = DW'(abs_im);
         end
         cau_pkg::OP_MUL: begin
            rem_a_in = (DW'(abs_re) + HALF) >> F;
            rem_b_in = (DW'(abs_im) + HALF) >> F;
         end
         cau_pkg::OP_DIV: begin
            rem_a_in = (DW'(abs_re) << F) + DW'(den_ff >> 1);
            rem_b_in = (DW'(abs_im) << F) + DW'(den_ff >> 1);
         end
         default: begin
            rem_a_in = '0;
            rem_b_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c4_ff <= '0;
      end else if (adv) begin
         c4_ff <= c4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_a_ff <= rem_a_in;
         rem_b_ff <= rem_b_in;
         den4_ff  <= den_ff;
      end
   end

   assign dn_ctl   = c4_ff;
   assign dn_rem_a = rem_a_ff;
   assign dn_rem_b = rem_b_ff;
   assign dn_den   = den4_ff;

endmodule

`default_nettype wire

// File: rtl/core/cau_iter.sv
// One digit stage shared by the two quotient lanes and the square root.
`default_nettype none

module cau_iter #(
   parameter int W = 32,
   parameter int F = 16,
   parameter int K = 0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire cau_pkg::ctl_type up_ctl,
   input  wire logic [3*W+F:0] up_rem_a,
   input  wire logic [3*W+F:0] up_rem_b,
   input  wire logic [W:0]    up_q_a,
   input  wire logic [W:0]    up_q_b,
   input  wire logic [2*W-1:0] up_den,
   output cau_pkg::ctl_type   dn_ctl,
   output logic [3*W+F:0]     dn_rem_a,
   output logic [3*W+F:0]     dn_rem_b,
   output logic [W:0]         dn_q_a,
   output logic [W:0]         dn_q_b,
   output logic [2*W-1:0]     dn_den
);

   localparam int DW = 3 * W + F + 1;

   cau_pkg::ctl_type ctl_ff;
   logic [DW-1:0]    rem_a_ff, rem_b_ff, rem_a_in, rem_b_in;
   logic [W:0]       q_a_ff, q_b_ff, q_a_in, q_b_in;
   logic [2*W-1:0]   den_ff;
   logic [DW-1:0]    dsh, root_t, tgt_a;
   logic             is_div, is_mag, take_a, take_b;

   // Lane a divides or extracts one root digit; lane b only divides.
   always_comb begin
      is_div   = (up_ctl.op == cau_pkg::OP_DIV);
      is_mag   = (up_ctl.op == cau_pkg::OP_MAG);
      dsh      = DW'(up_den) << K;
      root_t   = (DW'(up_q_a) << (K + 1)) + (DW'(1) << (2 * K));
      tgt_a    = is_mag ? root_t : dsh;
      take_a   = (is_div || is_mag) && (up_rem_a >= tgt_a);
      take_b   = is_div && (up_rem_b >= dsh);
      rem_a_in = take_a ? up_rem_a - tgt_a : up_rem_a;
      rem_b_in = take_b ? up_rem_b - dsh : up_rem_b;
      q_a_in    = up_q_a;
      q_a_in[K] = take_a;
      q_b_in    = up_q_b;
      q_b_in[K] = take_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_a_ff <= rem_a_in;
         rem_b_ff <= rem_b_in;
         q_a_ff   <= q_a_in;
         q_b_ff   <= q_b_in;
         den_ff   <= up_den;
      end
   end

   assign dn_ctl   = ctl_ff;
   assign dn_rem_a = rem_a_ff;
   assign dn_rem_b = rem_b_ff;
   assign dn_q_a   = q_a_ff;
   assign dn_q_b   = q_b_ff;
   assign dn_den   = den_ff;

endmodule

`default_nettype wire

// File: rtl/core/cau_back.sv
// Back end: picks each part's magnitude, rounds the root, saturates, registers the response.
`default_nettype none

module cau_back #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire cau_pkg::ctl_type   up_ctl,
   input  wire logic [3*W+F:0]     up_rem_a,
   input  wire logic [3*W+F:0]     up_rem_b,
   input  wire logic [W:0]         up_q_a,
   input  wire logic [W:0]         up_q_b,
   output logic                    rsp_valid,
   output logic signed [W-1:0]     rsp_res_real,
   output logic signed [W-1:0]     rsp_res_imag,
   output logic                    rsp_div_by_zero,
   output logic                    rsp_saturated
);

   localparam int DW = 3 * W + F + 1;
   localparam logic [DW-1:0] TOP = DW'(1) << (W - 1);

   // First stage: magnitude of each part, with round to nearest on the root.
   cau_pkg::ctl_type c1_ff;
   logic [DW-1:0]    m_re_ff, m_im_ff, m_re_in, m_im_in;

   always_comb begin
      unique case (up_ctl.op)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL: begin
            m_re_in = up_rem_a;
            m_im_in = up_rem_b;
         end
         cau_pkg::OP_DIV: begin
            m_re_in = DW'(up_q_a);
            m_im_in = DW'(up_q_b);
         end
         cau_pkg::OP_MAG: begin
            m_re_in = DW'(up_q_a) + DW'(up_rem_a > DW'(up_q_a));
            m_im_in = '0;
         end
         default: begin
            m_re_in = '0;
            m_im_in = '0;
         end
      endcase
      if (up_ctl.dz) begin
         m_re_in = '0;
         m_im_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
      end else if (adv) begin
         c1_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_re_ff <= m_re_in;
         m_im_ff <= m_im_in;
      end
   end

   // Second stage: clip to the signed range and restore the sign.
   logic [DW-1:0]   lim_re, lim_im, mag_re, mag_im;
   logic            sat_re, sat_im;
   logic [W-1:0]    w_re, w_im;
   logic            valid_ff;
   logic signed [W-1:0] res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic            dz_ff, sat_ff;

   always_comb begin
      lim_re    = c1_ff.neg_re ? TOP : TOP - DW'(1);
      lim_im    = c1_ff.neg_im ? TOP : TOP - DW'(1);
      sat_re    = m_re_ff > lim_re;
      sat_im    = m_im_ff > lim_im;
      mag_re    = sat_re ? lim_re : m_re_ff;
      mag_im    = sat_im ? lim_im : m_im_ff;
      w_re      = mag_re[W-1:0];
      w_im      = mag_im[W-1:0];
      res_re_in = c1_ff.neg_re ? -w_re : w_re;
      res_im_in = c1_ff.neg_im ? -w_im : w_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= c1_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         dz_ff     <= c1_ff.dz;
         sat_ff    <= sat_re || sat_im;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_res_real    = res_re_ff;
   assign rsp_res_imag    = res_im_ff;
   assign rsp_div_by_zero = dz_ff;
   assign rsp_saturated   = sat_ff;

endmodule

`default_nettype wire

// File: dv/complex_arithmetic_unit_top_tb.sv
// Self-checking testbench for the complex arithmetic unit, with a scoreboard and random stimulus.
`default_nettype none

module complex_arithmetic_unit_top_tb;

   localparam int WW         = 32;
   localparam int FB         = 16;
   localparam int RAND_ITEMS = 1750;
   localparam int CYCLE_LIMIT = 60000;

   typedef struct {
      logic [2:0]          op;
      logic signed [WW-1:0] ar, ai, br, bi;
   } operands_type;

   typedef struct {
      logic signed [WW-1:0] re, im;
      logic                 dz, sat;
   } answer_type;

   // Scoreboard: works out each answer when a request is taken and checks responses in order.
   class answer_book;
      answer_type due[$];
      int      errors = 0;
      int      checked = 0;
      int      op_seen[8];

      // Clips a sign and magnitude to the word range.
      function logic [WW-1:0] clip(logic neg, logic [127:0] mag, inout logic sat);
         logic [127:0] lim;
         lim = neg ? (128'd1 << (WW-1)) : ((128'd1 << (WW-1)) - 1);
         if (mag > lim) begin
            sat = 1'b1;
            mag = lim;
         end
         return neg ? WW'(-mag) : WW'(mag);
      endfunction

      function logic [127:0] absval(logic signed [127:0] v);
         return v < 0 ? -v : v;
      endfunction

      // Integer square root rounded to nearest.
      function logic [127:0] root(logic [127:0] n);
         logic [127:0] r, c;
         r = 0;
         for (int i = 47; i >= 0; i--) begin
            c = r | (128'd1 << i);
            if (c * c <= n) r = c;
         end
         if (n - r * r > r) r = r + 1;
         return r;
      endfunction

      function answer_type compute_answer(operands_type q);
         logic signed [127:0] ar, ai, br, bi, vr, vi;
         logic [127:0]        den, mr, mi;
         answer_type          a;
         ar = q.ar; ai = q.ai; br = q.br; bi = q.bi;
         a.re = 0; a.im = 0; a.dz = 0; a.sat = 0;
         case (q.op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
               vr = (q.op == cau_pkg::OP_ADD) ? ar + br : ar - br;
               vi = (q.op == cau_pkg::OP_ADD) ? ai + bi : ai - bi;
               a.re = clip(vr < 0, absval(vr), a.sat);
               a.im = clip(vi < 0, absval(vi), a.sat);
            end
            cau_pkg::OP_MUL: begin
               vr = ar * br - ai * bi;
               vi = ar * bi + ai * br;
               mr = (absval(vr) + (128'd1 << (FB-1))) >> FB;
               mi = (absval(vi) + (128'd1 << (FB-1))) >> FB;
               a.re = clip(vr < 0, mr, a.sat);
               a.im = clip(vi < 0, mi, a.sat);
            end
            cau_pkg::OP_DIV: begin
               den = br * br + bi * bi;
               if (den == 0) begin
                  a.dz = 1'b1;
               end else begin
                  vr = ar * br + ai * bi;
                  vi = ai * br - ar * bi;
                  mr = ((absval(vr) << FB) + (den >> 1)) / den;
                  mi = ((absval(vi) << FB) + (den >> 1)) / den;
                  a.re = clip(vr < 0, mr, a.sat);
                  a.im = clip(vi < 0, mi, a.sat);
               end
            end
            cau_pkg::OP_MAG: begin
               a.re = clip(1'b0, root(ar * ar + ai * ai), a.sat);
            end
            default: ;
         endcase
         return a;
      endfunction

      function void note_request(operands_type q);
         due.push_back(compute_answer(q));
         op_seen[q.op]++;
      endfunction

      function void check_response(answer_type got);
         answer_type want;
         if (due.size() == 0) begin
            $display("%0t: response with none outstanding: re %h im %h", $time, got.re, got.im);
            errors++;
            return;
         end
         want = due.pop_front();
         checked++;
         if (got.re !== want.re) begin
            $display("%0t: res_real expected %h actual %h", $time, want.re, got.re);
            errors++;
         end
         if (got.im !== want.im) begin
            $display("%0t: res_imag expected %h actual %h", $time, want.im, got.im);
            errors++;
         end
         if (got.dz !== want.dz) begin
            $display("%0t: div_by_zero expected %b actual %b", $time, want.dz, got.dz);
            errors++;
         end
         if (got.sat !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_operation = '0;
   logic signed [WW-1:0] req_a_real = '0, req_a_imag = '0, req_b_real = '0, req_b_imag = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [WW-1:0] rsp_res_real, rsp_res_imag;
   logic rsp_div_by_zero, rsp_saturated;

   int unsigned cycle = 0;
   answer_book  book = new();

   complex_arithmetic_unit_top #(.WORD_WIDTH(WW), .FRAC_BITS(FB)) uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Windows by cycle count: no idling on either side, then a long receiver hold-off.
   function automatic logic calm();
      return cycle >= 600 && cycle < 1000;
   endfunction

   function automatic logic held();
      return cycle >= 1300 && cycle < 1500;
   endfunction

   // Receiver: checks responses, drives the stall and watches the limit.
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (!reset && rsp_valid && !rsp_stall)
         book.check_response('{rsp_res_real, rsp_res_imag, rsp_div_by_zero, rsp_saturated});
      if (held())
         rsp_stall <= 1'b1;
      else if (calm())
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < 29);
      if (cycle > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle);
         $display("simulation failed");
         $finish;
      end
   end

   // Offers one request, with random idle cycles first, and waits for it to be taken.
   task automatic send_request(logic [2:0] op, logic [WW-1:0] ar, ai, br, bi);
      operands_type q;
      while (!calm() && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      q = '{op, ar, ai, br, bi};
      req_valid     <= 1'b1;
      req_operation <= op;
      req_a_real    <= ar;
      req_a_imag    <= ai;
      req_b_real    <= br;
      req_b_imag    <= bi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(q);
   endtask

   // Operand picker: moderate values most often, some full range, some at the edges.
   function automatic logic [WW-1:0] pick_part();
      int unsigned k;
      k = $urandom_range(9);
      if (k < 4) return WW'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
      if (k < 7) return $urandom;
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return 32'h0001_0000;
      endcase
   endfunction

   localparam logic [WW-1:0] MAXW = 32'h7fff_ffff;
   localparam logic [WW-1:0] MINW = 32'h8000_0000;
   localparam logic [WW-1:0] ONE  = 32'h0001_0000;

   initial begin
      logic [2:0]   op;
      logic [WW-1:0] br, bi;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: every operation, range extremes, divide by zero, unused codes.
      send_request(cau_pkg::OP_ADD, MAXW, MINW, MAXW, MINW);
      send_request(cau_pkg::OP_ADD, MINW, MAXW, 32'hffff_ffff, 32'h1);
      send_request(cau_pkg::OP_SUB, MINW, MAXW, 32'h1, 32'hffff_ffff);
      send_request(cau_pkg::OP_SUB, MAXW, MINW, MAXW, MINW);
      send_request(cau_pkg::OP_MUL, ONE, ONE, ONE, 32'hffff_0000);
      send_request(cau_pkg::OP_MUL, MINW, MINW, MINW, MINW);
      send_request(cau_pkg::OP_MUL, MAXW, MINW, MINW, MAXW);
      send_request(cau_pkg::OP_MUL, 32'h0000_8000, 32'h0, 32'h0000_0001, 32'h0);
      send_request(cau_pkg::OP_MUL, 32'hffff_8000, 32'h0, 32'h0000_0001, 32'h0);
      send_request(cau_pkg::OP_DIV, ONE, ONE, 32'h0, 32'h0);
      send_request(cau_pkg::OP_DIV, MAXW, MINW, 32'h0, 32'h0);
      send_request(cau_pkg::OP_DIV, ONE, 32'h0, 32'h0003_0000, 32'h0);
      send_request(cau_pkg::OP_DIV, MINW, MAXW, 32'h1, 32'h0);
      send_request(cau_pkg::OP_DIV, MAXW, MAXW, MINW, MINW);
      send_request(cau_pkg::OP_DIV, 32'h0, 32'h0, 32'h0, 32'h1);
      send_request(cau_pkg::OP_MAG, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
      send_request(cau_pkg::OP_MAG, MINW, MINW, MAXW, MAXW);
      send_request(cau_pkg::OP_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
      send_request(cau_pkg::OP_MAG, 32'h1, 32'h1, 32'h0, 32'h0);
      send_request(3'd5, MAXW, MAXW, MAXW, MAXW);
      send_request(3'd6, MINW, MINW, 32'h0, 32'h0);
      send_request(3'd7, ONE, ONE, ONE, ONE);

      // Random requests, weighted towards the real operations.
      for (int n = 0; n < RAND_ITEMS; n++) begin
         op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
         br = pick_part();
         bi = pick_part();
         if (op == cau_pkg::OP_DIV && $urandom_range(19) == 0) begin
            br = '0;
            bi = '0;
         end
         send_request(op, pick_part(), pick_part(), br, bi);
      end
      req_valid <= 1'b0;

      // Drain the pipeline, then allow for its depth.
      while (book.due.size() != 0) @(posedge clock);
      repeat (WW + 20) @(posedge clock);

      $display("Checked %0d responses: add %0d, sub %0d, mul %0d, div %0d, mag %0d, unused %0d.",
               book.checked, book.op_seen[cau_pkg::OP_ADD], book.op_seen[cau_pkg::OP_SUB],
               book.op_seen[cau_pkg::OP_MUL], book.op_seen[cau_pkg::OP_DIV],
               book.op_seen[cau_pkg::OP_MAG],
               book.op_seen[5] + book.op_seen[6] + book.op_seen[7]);
      $display("Mismatches found: %0d, over %0d cycles.", book.errors, cycle);
      if (book.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
